// ===== hw/rtl/rsmap_pkg.sv =====
// Shared types and constants for the redshift-space particle mapper.
`timescale 1ns / 1ps
`default_nettype none

package rsmap_pkg;

  localparam int unsigned NAX = 3;

  localparam int unsigned BOX_LEN_X = 256;
  localparam int unsigned BOX_LEN_Y = 256;
  localparam int unsigned BOX_LEN_Z = 256;

  // Datapath widths.
  localparam int unsigned DW   = 32;  // field width
  localparam int unsigned XW   = 34;  // position plus origin, signed
  localparam int unsigned VW   = 33;  // velocity plus observer velocity, signed
  localparam int unsigned XMW  = 33;  // magnitude of x
  localparam int unsigned R2W  = 68;  // squared radius
  localparam int unsigned VMW  = 67;  // magnitude of line-of-sight product
  localparam int unsigned NUMW = 99;  // factor times line-of-sight product
  localparam int unsigned QW   = 48;  // scale magnitude, Q16.32
  localparam int unsigned UW   = 36;  // biased box index for the wrap

  // The wrap works on floor(s / 2^16), made nonnegative by a multiple of the
  // box length, and reduced with a reciprocal estimate that is off by at most one.
  localparam longint unsigned TWO34 = 64'd1 << 34;
  localparam longint unsigned TWO36 = 64'd1 << 36;

  localparam longint unsigned BIAS_X =
    64'(BOX_LEN_X) * ((TWO34 + 64'(BOX_LEN_X) - 64'd1) / 64'(BOX_LEN_X));
  localparam longint unsigned BIAS_Y =
    64'(BOX_LEN_Y) * ((TWO34 + 64'(BOX_LEN_Y) - 64'd1) / 64'(BOX_LEN_Y));
  localparam longint unsigned BIAS_Z =
    64'(BOX_LEN_Z) * ((TWO34 + 64'(BOX_LEN_Z) - 64'd1) / 64'(BOX_LEN_Z));

  localparam longint unsigned RECIP_X = TWO36 / 64'(BOX_LEN_X);
  localparam longint unsigned RECIP_Y = TWO36 / 64'(BOX_LEN_Y);
  localparam longint unsigned RECIP_Z = TWO36 / 64'(BOX_LEN_Z);

  localparam logic [15:0] BOX_LEN [NAX] = '{16'(BOX_LEN_X), 16'(BOX_LEN_Y), 16'(BOX_LEN_Z)};
  localparam logic [UW-1:0] BIAS [NAX] = '{UW'(BIAS_X), UW'(BIAS_Y), UW'(BIAS_Z)};
  localparam logic [UW:0] RECIP [NAX] = '{(UW+1)'(RECIP_X), (UW+1)'(RECIP_Y),
                                          (UW+1)'(RECIP_Z)};

  typedef enum logic [2:0] {
    CFG_OBS_VEL_X = 3'd0,
    CFG_OBS_VEL_Y = 3'd1,
    CFG_OBS_VEL_Z = 3'd2,
    CFG_ORIGIN_X  = 3'd3,
    CFG_ORIGIN_Y  = 3'd4,
    CFG_ORIGIN_Z  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]    index;
    logic [DW-1:0] wdata;
  } rsmap_cfg_t;

  typedef struct packed {
    logic [DW-1:0] pos_x;
    logic [DW-1:0] pos_y;
    logic [DW-1:0] pos_z;
    logic [DW-1:0] vel_x;
    logic [DW-1:0] vel_y;
    logic [DW-1:0] vel_z;
    logic [DW-1:0] rsd_factor;
  } rsmap_in_t;

  typedef struct packed {
    logic [DW-1:0] shifted_x;
    logic [DW-1:0] shifted_y;
    logic [DW-1:0] shifted_z;
    logic          zero_radius;
  } rsmap_out_t;

  // Per-particle data that rides alongside the divider.
  typedef struct packed {
    logic [NAX-1:0][DW-1:0]  pos;
    logic [NAX-1:0][XMW-1:0] xmag;
    logic [NAX-1:0]          xneg;
    logic                    vneg;
    logic                    zr;
  } rsmap_side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsmap_if.sv =====
// Valid/ready channel interfaces for the mapper's configuration, input and output.
`timescale 1ns / 1ps
`default_nettype none

interface rsmap_cfg_if import rsmap_pkg::*; ();
  logic       valid;
  logic       ready;
  rsmap_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsmap_in_if import rsmap_pkg::*; ();
  logic      valid;
  logic      ready;
  rsmap_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsmap_out_if import rsmap_pkg::*; ();
  logic       valid;
  logic       ready;
  rsmap_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rsmap_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation.
`timescale 1ns / 1ps
`default_nettype none

module rsmap_div import rsmap_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NUMW-1:0]   num_i,
  input  logic [R2W-1:0]    den_i,
  input  rsmap_side_t       side_i,
  output logic              vld_o,
  output logic [QW-1:0]     quo_o,
  output logic              sat_o,
  output rsmap_side_t       side_o
);

  localparam int unsigned NHW = NUMW - QW;

  logic        vld_q  [QW+1];
  logic [R2W-1:0] rem_q [QW+1];
  logic [R2W-1:0] den_q [QW+1];
  logic [QW-1:0]  nlo_q [QW+1];
  logic [QW-1:0]  quo_q [QW+1];
  logic           sat_q [QW+1];
  rsmap_side_t    side_q [QW+1];

  logic [R2W:0]   trial [QW+1];
  logic           ge    [QW+1];
  logic [R2W-1:0] rem_d [QW+1];

  // Stage k brings down the next numerator bit and tries one subtraction.
  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    rem_d[0] = '0;
    for (int k = 1; k <= QW; k++) begin
      trial[k] = {rem_q[k-1], nlo_q[k-1][QW-1]};
      ge[k]    = trial[k] >= {1'b0, den_q[k-1]};
      rem_d[k] = ge[k] ? R2W'(trial[k] - {1'b0, den_q[k-1]}) : trial[k][R2W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k <= QW; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // A quotient of 2^48 or more shows as a high part no smaller than the divisor.
      rem_q[0]  <= R2W'(num_i[NUMW-1:QW]);
      nlo_q[0]  <= num_i[QW-1:0];
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      sat_q[0]  <= {{(R2W-NHW){1'b0}}, num_i[NUMW-1:QW]} >= den_i;
      side_q[0] <= side_i;
      for (int k = 1; k <= QW; k++) begin
        rem_q[k]  <= rem_d[k];
        nlo_q[k]  <= {nlo_q[k-1][QW-2:0], 1'b0};
        den_q[k]  <= den_q[k-1];
        quo_q[k]  <= {quo_q[k-1][QW-2:0], ge[k]};
        sat_q[k]  <= sat_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign vld_o  = vld_q[QW];
  assign quo_o  = quo_q[QW];
  assign sat_o  = sat_q[QW];
  assign side_o = side_q[QW];

`ifndef SYNTH
  a_init_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !sat_q[0] |-> rem_q[0] < den_q[0])
    else $error("divider start remainder not below divisor");
  a_final_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QW] && !sat_q[QW] |-> rem_q[QW] < den_q[QW])
    else $error("divider final remainder not below divisor");
  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QW] && side_q[QW].zr |-> sat_q[QW])
    else $error("zero divisor did not flag saturation");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/redshift_space_particle_map_core.sv =====
// Redshift-space particle mapper: moves each particle along its radius and wraps it.
//
// Channels: cfg_i writes one of six registers per beat (observer velocity x/y/z at
// indexes 0..2, box origin x/y/z at 3..5; other indexes are dropped) and is always
// ready. in_i carries one particle per beat; out_o returns one result beat per
// particle, in order.
// One particle enters per cycle while out_o is not stalled: six front stages form
// offsets, products, sums and the numerator, a 49-stage divider loads its operands
// and then yields one quotient bit per stage, then three stages scale the position
// and four reduce it modulo the box length with a reciprocal.
// When the output beat is stalled the whole pipeline holds, so in_i.ready follows
// out_o.ready while a result waits; nothing is dropped or repeated.
// Reset clears the configuration registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module redshift_space_particle_map_core import rsmap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsmap_cfg_if.sink   cfg_i,
  rsmap_in_if.sink    in_i,
  rsmap_out_if.source out_o
);

  logic adv;
  logic [DW-1:0] obs_vel_q [NAX];
  logic [DW-1:0] origin_q  [NAX];

  logic [DW-1:0] in_pos [NAX];
  logic [DW-1:0] in_vel [NAX];

  // Front stages.
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q;
  logic signed [XW-1:0] s1_x_q [NAX];
  logic signed [VW-1:0] s1_v_q [NAX];
  logic [DW-1:0]        s1_p_q [NAX];
  logic [DW-1:0]        s1_f_q;

  logic signed [2*XW-1:0]   s2_xx_q [NAX];
  logic signed [XW+VW-1:0]  s2_xv_q [NAX];
  logic [XMW-1:0]           s2_xmag_q [NAX];
  logic [NAX-1:0]           s2_xneg_q;
  logic [DW-1:0]            s2_p_q [NAX];
  logic [DW-1:0]            s2_f_q;

  logic [R2W-1:0]           s3_r2_q;
  logic signed [VMW+1:0]    s3_vlos_q;
  logic [XMW-1:0]           s3_xmag_q [NAX];
  logic [NAX-1:0]           s3_xneg_q;
  logic [DW-1:0]            s3_p_q [NAX];
  logic [DW-1:0]            s3_f_q;

  logic [R2W-1:0]   s4_r2_q;
  logic [VMW-1:0]   s4_vmag_q;
  logic [DW-1:0]    s4_f_q;
  rsmap_side_t      s4_side_q;

  logic [DW+34-1:0]     s5_pl_q;
  logic [DW+VMW-34-1:0] s5_ph_q;
  logic [R2W-1:0]       s5_r2_q;
  rsmap_side_t          s5_side_q;

  logic [NUMW-1:0] s6_num_q;
  logic [R2W-1:0]  s6_r2_q;
  rsmap_side_t     s6_side_q;

  // Divider outputs.
  logic          dv_vld;
  logic [QW-1:0] dv_quo;
  logic          dv_sat;
  rsmap_side_t   dv_side;
  logic [QW-1:0] amag;

  // Scaling and wrap stages.
  logic p1_vld_q, p2_vld_q, p3_vld_q, m1_vld_q, m2_vld_q, m3_vld_q, m4_vld_q;
  logic [QW/2+XMW-1:0] p1_ml_q [NAX];
  logic [QW/2+XMW-1:0] p1_mh_q [NAX];
  rsmap_side_t         p1_side_q;

  logic [QW+XMW-DW-1:0] p2_shm_q [NAX];
  rsmap_side_t          p2_side_q;

  logic signed [51:0] p3_s_q [NAX];
  logic               p3_zr_q;

  logic [UW-1:0] m1_u_q [NAX];
  logic [15:0]   m1_lo_q [NAX];
  logic          m1_zr_q;

  logic [UW/2+UW:0] m2_a_q [NAX];
  logic [UW/2+UW:0] m2_b_q [NAX];
  logic [15:0]      m2_u_q [NAX];
  logic [15:0]      m2_lo_q [NAX];
  logic             m2_zr_q;

  logic [UW-1:0] m3_qe_q [NAX];
  logic [15:0]   m3_u_q [NAX];
  logic [15:0]   m3_lo_q [NAX];
  logic          m3_zr_q;

  logic [15:0] m4_ql_q [NAX];
  logic [15:0] m4_u_q [NAX];
  logic [15:0] m4_lo_q [NAX];
  logic        m4_zr_q;

  logic        out_vld_q;
  rsmap_out_t  out_q;

  // Combinational per-stage values.
  logic signed [XW-1:0]  s1_x_d [NAX];
  logic signed [VW-1:0]  s1_v_d [NAX];
  logic [XMW-1:0]        s2_xmag_d [NAX];
  logic [VMW-1:0]        s4_vmag_d;
  logic [NUMW-1:0]       s6_num_d;
  logic [QW+XMW-1:0]     p2_prod [NAX];
  logic signed [51:0]    p3_sh [NAX];
  logic signed [51:0]    m1_h [NAX];
  logic [UW/2+UW+18:0]   m3_sum [NAX];
  logic [31:0]           m4_prod [NAX];
  logic [15:0]           wr_r0 [NAX];
  logic [15:0]           wr_r [NAX];

  assign adv         = !out_vld_q || out_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;

  assign in_pos[0] = in_i.data.pos_x;
  assign in_pos[1] = in_i.data.pos_y;
  assign in_pos[2] = in_i.data.pos_z;
  assign in_vel[0] = in_i.data.vel_x;
  assign in_vel[1] = in_i.data.vel_y;
  assign in_vel[2] = in_i.data.vel_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NAX; i++) begin
        obs_vel_q[i] <= '0;
        origin_q[i]  <= '0;
      end
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.data.index))
        CFG_OBS_VEL_X: obs_vel_q[0] <= cfg_i.data.wdata;
        CFG_OBS_VEL_Y: obs_vel_q[1] <= cfg_i.data.wdata;
        CFG_OBS_VEL_Z: obs_vel_q[2] <= cfg_i.data.wdata;
        CFG_ORIGIN_X:  origin_q[0]  <= cfg_i.data.wdata;
        CFG_ORIGIN_Y:  origin_q[1]  <= cfg_i.data.wdata;
        CFG_ORIGIN_Z:  origin_q[2]  <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      s1_x_d[i] = $signed({2'b00, in_pos[i]}) + $signed({{2{origin_q[i][DW-1]}}, origin_q[i]});
      s1_v_d[i] = $signed({in_vel[i][DW-1], in_vel[i]})
                + $signed({obs_vel_q[i][DW-1], obs_vel_q[i]});
      s2_xmag_d[i] = s1_x_q[i][XW-1] ? XMW'(-s1_x_q[i]) : s1_x_q[i][XMW-1:0];
    end
    s4_vmag_d = s3_vlos_q[VMW+1] ? VMW'(-s3_vlos_q) : s3_vlos_q[VMW-1:0];
    s6_num_d  = NUMW'(s5_pl_q) + (NUMW'(s5_ph_q) << 34);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NAX; i++) begin
        s1_x_q[i] <= s1_x_d[i];
        s1_v_q[i] <= s1_v_d[i];
        s1_p_q[i] <= in_pos[i];

        s2_xx_q[i]   <= (2*XW)'(s1_x_q[i]) * (2*XW)'(s1_x_q[i]);
        s2_xv_q[i]   <= (XW+VW)'(s1_x_q[i]) * (XW+VW)'(s1_v_q[i]);
        s2_xmag_q[i] <= s2_xmag_d[i];
        s2_xneg_q[i] <= s1_x_q[i][XW-1];
        s2_p_q[i]    <= s1_p_q[i];

        s3_xmag_q[i] <= s2_xmag_q[i];
        s3_p_q[i]    <= s2_p_q[i];

        s4_side_q.pos[i]  <= s3_p_q[i];
        s4_side_q.xmag[i] <= s3_xmag_q[i];
      end
      s1_f_q <= in_i.data.rsd_factor;
      s2_f_q <= s1_f_q;

      s3_r2_q   <= R2W'($unsigned(s2_xx_q[0])) + R2W'($unsigned(s2_xx_q[1]))
                 + R2W'($unsigned(s2_xx_q[2]));
      s3_vlos_q <= (VMW+2)'(s2_xv_q[0]) + (VMW+2)'(s2_xv_q[1]) + (VMW+2)'(s2_xv_q[2]);
      s3_xneg_q <= s2_xneg_q;
      s3_f_q    <= s2_f_q;

      s4_r2_q        <= s3_r2_q;
      s4_vmag_q      <= s4_vmag_d;
      s4_f_q         <= s3_f_q;
      s4_side_q.xneg <= s3_xneg_q;
      s4_side_q.vneg <= s3_vlos_q[VMW+1];
      s4_side_q.zr   <= s3_r2_q == '0;

      // The wide numerator product is split at bit 34 of the magnitude.
      s5_pl_q   <= (DW+34)'(s4_f_q) * (DW+34)'(s4_vmag_q[33:0]);
      s5_ph_q   <= (DW+VMW-34)'(s4_f_q) * (DW+VMW-34)'(s4_vmag_q[VMW-1:34]);
      s5_r2_q   <= s4_r2_q;
      s5_side_q <= s4_side_q;

      s6_num_q  <= s6_num_d;
      s6_r2_q   <= s5_r2_q;
      s6_side_q <= s5_side_q;
    end
  end

  rsmap_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s6_vld_q),
    .num_i  (s6_num_q),
    .den_i  (s6_r2_q),
    .side_i (s6_side_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .sat_o  (dv_sat),
    .side_o (dv_side)
  );

  // A zero radius forces no shift; an overflowing quotient clamps to all ones.
  assign amag = dv_side.zr ? '0 : (dv_sat ? '1 : dv_quo);

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      p2_prod[i] = (QW+XMW)'(p1_ml_q[i]) + ((QW+XMW)'(p1_mh_q[i]) << (QW/2));
      p3_sh[i]   = (p2_side_q.vneg ^ p2_side_q.xneg[i])
                 ? -$signed({3'b000, p2_shm_q[i]}) : $signed({3'b000, p2_shm_q[i]});
      m1_h[i]    = p3_s_q[i] >>> 16;
      m3_sum[i]  = (UW/2+UW+19)'(m2_a_q[i]) + ((UW/2+UW+19)'(m2_b_q[i]) << (UW/2));
      m4_prod[i] = 32'(m3_qe_q[i][15:0]) * 32'(BOX_LEN[i]);
      wr_r0[i]   = m4_u_q[i] - m4_ql_q[i];
      wr_r[i]    = (wr_r0[i] >= BOX_LEN[i]) ? wr_r0[i] - BOX_LEN[i] : wr_r0[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      m1_vld_q  <= 1'b0;
      m2_vld_q  <= 1'b0;
      m3_vld_q  <= 1'b0;
      m4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      p1_vld_q  <= dv_vld;
      p2_vld_q  <= p1_vld_q;
      p3_vld_q  <= p2_vld_q;
      m1_vld_q  <= p3_vld_q;
      m2_vld_q  <= m1_vld_q;
      m3_vld_q  <= m2_vld_q;
      m4_vld_q  <= m3_vld_q;
      out_vld_q <= m4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NAX; i++) begin
        p1_ml_q[i]  <= (QW/2+XMW)'(amag[QW/2-1:0]) * (QW/2+XMW)'(dv_side.xmag[i]);
        p1_mh_q[i]  <= (QW/2+XMW)'(amag[QW-1:QW/2]) * (QW/2+XMW)'(dv_side.xmag[i]);
        p2_shm_q[i] <= p2_prod[i][QW+XMW-1:DW];
        p3_s_q[i]   <= $signed({20'd0, p2_side_q.pos[i]}) + p3_sh[i];

        // The box length is a whole number of units, so only the integer part wraps.
        m1_u_q[i]  <= m1_h[i][UW-1:0] + BIAS[i];
        m1_lo_q[i] <= p3_s_q[i][15:0];

        m2_a_q[i]  <= (UW/2+UW+1)'(m1_u_q[i][UW/2-1:0]) * (UW/2+UW+1)'(RECIP[i]);
        m2_b_q[i]  <= (UW/2+UW+1)'(m1_u_q[i][UW-1:UW/2]) * (UW/2+UW+1)'(RECIP[i]);
        m2_u_q[i]  <= m1_u_q[i][15:0];
        m2_lo_q[i] <= m1_lo_q[i];

        m3_qe_q[i] <= m3_sum[i][2*UW-1:UW];
        m3_u_q[i]  <= m2_u_q[i];
        m3_lo_q[i] <= m2_lo_q[i];

        m4_ql_q[i] <= m4_prod[i][15:0];
        m4_u_q[i]  <= m3_u_q[i];
        m4_lo_q[i] <= m3_lo_q[i];
      end
      p1_side_q <= dv_side;
      p2_side_q <= p1_side_q;
      p3_zr_q   <= p2_side_q.zr;
      m1_zr_q   <= p3_zr_q;
      m2_zr_q   <= m1_zr_q;
      m3_zr_q   <= m2_zr_q;
      m4_zr_q   <= m3_zr_q;

      out_q.shifted_x   <= {wr_r[0], m4_lo_q[0]};
      out_q.shifted_y   <= {wr_r[1], m4_lo_q[1]};
      out_q.shifted_z   <= {wr_r[2], m4_lo_q[2]};
      out_q.zero_radius <= m4_zr_q;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

`ifndef SYNTH
  a_recip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m4_vld_q |-> (wr_r0[0] < 17'(BOX_LEN[0]) * 2) && (wr_r0[1] < 17'(BOX_LEN[1]) * 2)
              && (wr_r0[2] < 17'(BOX_LEN[2]) * 2))
    else $error("reciprocal estimate off by more than one");
  a_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.shifted_x[31:16] < BOX_LEN[0])
               && (out_q.shifted_y[31:16] < BOX_LEN[1])
               && (out_q.shifted_z[31:16] < BOX_LEN[2]))
    else $error("wrapped position outside the box");
  a_zero_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_vld_q && p2_side_q.zr |-> p2_shm_q[0] == '0 && p2_shm_q[1] == '0
                                && p2_shm_q[2] == '0)
    else $error("zero radius produced a nonzero shift");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> out_vld_q && $stable(out_q))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
